### rtl/core/hvn_pkg.sv
// hvn_pkg: shared types and constants of the heightmap vertex normal block
// no dependencies

package hvn_pkg;

  // configuration port
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_RECIP = 2'd2;

  localparam int SIZE_W   = 11;
  localparam int RECIP_W  = 24;
  localparam int HEIGHT_W = 24;
  localparam int ROW_W    = 10;
  localparam int OUT_W    = 16;

  // working vector component: wide enough for height differences and normal sums
  localparam int VEC_W = 26;
  typedef logic signed [VEC_W-1:0] comp_t;
  typedef struct packed {
    comp_t x;
    comp_t y;
    comp_t z;
  } vec_t;

  // y component of every face vector, -1.0 in Q.8
  localparam comp_t FACE_Y = -comp_t'(256);

endpackage

### rtl/core/hvn_ram.sv
// hvn_ram: generic single write port, single read port ram with registered read
// no dependencies

module hvn_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/hvn_norm.sv
// hvn_norm: iterative vector normalizer (sum of squares, bit-pair root, restoring divide)
// depends on hvn_pkg

module hvn_norm #(
  parameter int FRAC_BITS = 14
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  hvn_pkg::vec_t               vec_in,
  output logic                        done,
  output logic signed [FRAC_BITS+1:0] nx,
  output logic signed [FRAC_BITS+1:0] ny,
  output logic signed [FRAC_BITS+1:0] nz
);

  localparam int FCW   = FRAC_BITS + 2;
  localparam int MAG_W = hvn_pkg::VEC_W - 1;
  localparam int SQ_W  = 2 * MAG_W + 2;
  localparam int RT_W  = SQ_W / 2;
  localparam int NUMW  = MAG_W + FRAC_BITS + 1;
  localparam int CNT_W = $clog2(NUMW + 1);

  localparam logic [2:0] N_IDLE = 3'd0;
  localparam logic [2:0] N_SQ   = 3'd1;
  localparam logic [2:0] N_ROOT = 3'd2;
  localparam logic [2:0] N_LOAD = 3'd3;
  localparam logic [2:0] N_DIV  = 3'd4;
  localparam logic [2:0] N_DONE = 3'd5;

  logic [2:0]            state_r;
  hvn_pkg::vec_t         vec_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [1:0]            k_r;
  logic [2*MAG_W-1:0]    prod_r;
  logic [SQ_W-1:0]       sum_r;
  logic [SQ_W-1:0]       rad_r;
  logic [RT_W+1:0]       rem_r;
  logic [RT_W-1:0]       root_r;
  logic [NUMW-1:0]       num_r;
  logic [RT_W:0]         drem_r;
  logic [NUMW-1:0]       quo_r;
  logic signed [FCW-1:0] res_r [3];

  logic [1:0]            k_sel;
  hvn_pkg::comp_t        comp_sel;
  logic [MAG_W-1:0]      mag_sel;
  logic [SQ_W-1:0]       sum_full;
  logic [RT_W+1:0]       rt_rem;
  logic [RT_W+1:0]       rt_trial;
  logic [RT_W:0]         dv_rem;
  logic [RT_W:0]         dv_div;
  logic [NUMW-1:0]       quo_fin;
  logic [NUMW-1:0]       quo_neg;

  // component select and magnitude
  always_comb begin
    k_sel = (state_r == N_SQ) ? cnt_r[1:0] : k_r;
    case (k_sel)
      2'd1:    comp_sel = vec_r.y;
      2'd2:    comp_sel = vec_r.z;
      default: comp_sel = vec_r.x;
    endcase
    mag_sel = comp_sel[hvn_pkg::VEC_W-1] ? MAG_W'(-comp_sel) : MAG_W'(comp_sel);
  end

  // step datapaths
  always_comb begin
    sum_full = sum_r + SQ_W'(prod_r);
    rt_rem   = {rem_r[RT_W-1:0], rad_r[SQ_W-1 -: 2]};
    rt_trial = {root_r, 2'b01};
    dv_rem   = {drem_r[RT_W-1:0], num_r[NUMW-1]};
    dv_div   = {1'b0, root_r};
    quo_fin  = {quo_r[NUMW-2:0], (dv_rem >= dv_div)};
    quo_neg  = -quo_fin;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= N_IDLE;
      cnt_r   <= '0;
      k_r     <= '0;
    end else begin
      unique case (state_r)
        N_IDLE: begin
          if (start) begin
            vec_r   <= vec_in;
            cnt_r   <= '0;
            sum_r   <= '0;
            state_r <= N_SQ;
          end
        end
        // one square per cycle, accumulated in the next cycle
        N_SQ: begin
          if (cnt_r < CNT_W'(3)) begin
            prod_r <= mag_sel * mag_sel;
          end
          if (cnt_r != '0) begin
            sum_r <= sum_full;
          end
          if (cnt_r == CNT_W'(3)) begin
            cnt_r  <= '0;
            rad_r  <= sum_full;
            rem_r  <= '0;
            root_r <= '0;
            if (sum_full == '0) begin
              res_r[0] <= '0;
              res_r[1] <= '0;
              res_r[2] <= '0;
              state_r  <= N_DONE;
            end else begin
              state_r <= N_ROOT;
            end
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        // integer square root, two radicand bits per cycle
        N_ROOT: begin
          rad_r <= {rad_r[SQ_W-3:0], 2'b00};
          if (rt_rem >= rt_trial) begin
            rem_r  <= rt_rem - rt_trial;
            root_r <= {root_r[RT_W-2:0], 1'b1};
          end else begin
            rem_r  <= rt_rem;
            root_r <= {root_r[RT_W-2:0], 1'b0};
          end
          if (cnt_r == CNT_W'(RT_W - 1)) begin
            cnt_r   <= '0;
            k_r     <= '0;
            state_r <= N_LOAD;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        // rounded numerator of the current component
        N_LOAD: begin
          num_r   <= (NUMW'(mag_sel) << FRAC_BITS) + NUMW'(root_r >> 1);
          drem_r  <= '0;
          quo_r   <= '0;
          cnt_r   <= '0;
          state_r <= N_DIV;
        end
        // restoring division, one quotient bit per cycle
        N_DIV: begin
          num_r <= {num_r[NUMW-2:0], 1'b0};
          quo_r <= quo_fin;
          drem_r <= (dv_rem >= dv_div) ? (dv_rem - dv_div) : dv_rem;
          if (cnt_r == CNT_W'(NUMW - 1)) begin
            cnt_r <= '0;
            res_r[k_r] <= comp_sel[hvn_pkg::VEC_W-1] ? FCW'(quo_neg) : FCW'(quo_fin);
            if (k_r == 2'd2) begin
              state_r <= N_DONE;
            end else begin
              k_r     <= k_r + 1'b1;
              state_r <= N_LOAD;
            end
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        N_DONE: begin
          state_r <= N_IDLE;
        end
        default: begin
          state_r <= N_IDLE;
        end
      endcase
    end
  end

  assign done = (state_r == N_DONE);
  assign nx   = res_r[0];
  assign ny   = res_r[1];
  assign nz   = res_r[2];

endmodule

### rtl/core/heightmap_vertex_normals.sv
// heightmap_vertex_normals: streaming per-vertex normals of a height-field terrain
// depends on hvn_pkg, hvn_ram, hvn_norm
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall  in_height_sample
//   out_     output     out_valid/out_stall  out_normal_x/y/z, out_vertex_column,
//                                            out_vertex_row, out_last_vertex
//   cfg_     input      cfg_we               cfg_index, cfg_data
//
// one sample is worked on at a time; normalizations run in the shared iterative
// unit. a row 0 sample needs no normalization; later samples take 1 to 3
// normalizations. reset (synchronous, rst_n low) clears the counters and control;
// the line stores are not cleared. a stalled result stays in the output register
// while a new sample is accepted; the next result waits for that register to
// empty.

module heightmap_vertex_normals #(
  parameter int MAX_WIDTH        = 1024,
  parameter int SAMPLE_BITS      = 16,
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [SAMPLE_BITS-1:0]            in_height_sample,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [hvn_pkg::OUT_W-1:0]  out_normal_x,
  output logic signed [hvn_pkg::OUT_W-1:0]  out_normal_y,
  output logic signed [hvn_pkg::OUT_W-1:0]  out_normal_z,
  output logic [hvn_pkg::ROW_W-1:0]         out_vertex_column,
  output logic [hvn_pkg::ROW_W-1:0]         out_vertex_row,
  output logic                              out_last_vertex,
  input  logic                              cfg_we,
  input  logic [hvn_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hvn_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int CIW  = $clog2(MAX_WIDTH);
  localparam int FCW  = NORMAL_FRAC_BITS + 2;
  localparam int HW   = hvn_pkg::HEIGHT_W;
  localparam int RW   = hvn_pkg::ROW_W;
  localparam int PW   = SAMPLE_BITS + hvn_pkg::RECIP_W + 1;

  localparam logic [3:0] T_IDLE  = 4'd0;
  localparam logic [3:0] T_SCALE = 4'd1;
  localparam logic [3:0] T_RD1   = 4'd2;
  localparam logic [3:0] T_RD2   = 4'd3;
  localparam logic [3:0] T_FACE  = 4'd4;
  localparam logic [3:0] T_FWAIT = 4'd5;
  localparam logic [3:0] T_V1    = 4'd6;
  localparam logic [3:0] T_V1W   = 4'd7;
  localparam logic [3:0] T_PUT1  = 4'd8;
  localparam logic [3:0] T_V2    = 4'd9;
  localparam logic [3:0] T_V2W   = 4'd10;
  localparam logic [3:0] T_PUT2  = 4'd11;
  localparam logic [3:0] T_FIN   = 4'd12;

  // configuration registers
  logic [hvn_pkg::SIZE_W-1:0]  gw_r;
  logic [hvn_pkg::SIZE_W-1:0]  gh_r;
  logic [hvn_pkg::RECIP_W-1:0] recip_r;

  logic [3:0]             state_r;
  logic [CIW-1:0]         col_r;
  logic [RW-1:0]          row_r;
  logic [SAMPLE_BITS-1:0] raw_r;
  logic [HW-1:0]          hs_r;
  logic [HW-1:0]          h1_r;
  logic [HW-1:0]          h2_r;
  logic [3*FCW-1:0]       pfl_r;
  logic [3*FCW-1:0]       pfc_r;
  logic [3*FCW-1:0]       cur_r;
  logic [3*FCW-1:0]       left_r;
  logic                   out_valid_r;
  logic signed [hvn_pkg::OUT_W-1:0] onx_r, ony_r, onz_r;
  logic [RW-1:0]          ocol_r;
  logic [RW-1:0]          orow_r;
  logic                   olast_r;

  logic [CIW-1:0]         wm1;
  logic [RW-1:0]          hm1;
  logic                   lastcol;
  logic                   lastrow;
  logic                   has_cur;
  logic [PW-1:0]          prod;
  logic [PW-9:0]          sc;
  logic [HW-1:0]          hs_nxt;

  logic [CIW-1:0]         ht_raddr;
  logic [CIW-1:0]         fc_raddr;
  logic [HW-1:0]          ht_q;
  logic [3*FCW-1:0]       fc_q;
  logic                   ht_we;
  logic                   fc_we;

  logic                   norm_start;
  hvn_pkg::vec_t          norm_vec;
  logic                   norm_done;
  logic signed [FCW-1:0]  nx, ny, nz;
  logic [3*FCW-1:0]       norm_res;
  hvn_pkg::vec_t          face_vec;
  hvn_pkg::vec_t          sum1;
  hvn_pkg::vec_t          sum2;
  logic                   out_free;
  logic                   out_load;

  // clamped grid limits and position flags
  always_comb begin
    if (int'(gw_r) < 2) begin
      wm1 = CIW'(1);
    end else if (int'(gw_r) > MAX_WIDTH) begin
      wm1 = CIW'(MAX_WIDTH - 1);
    end else begin
      wm1 = CIW'(int'(gw_r) - 1);
    end
    if (int'(gh_r) < 2) begin
      hm1 = RW'(1);
    end else if (int'(gh_r) > 1024) begin
      hm1 = RW'(1023);
    end else begin
      hm1 = RW'(int'(gh_r) - 1);
    end
    lastcol = (col_r >= wm1);
    lastrow = (row_r >= hm1);
    has_cur = !lastcol;
  end

  // height scaling with saturation
  always_comb begin
    prod   = PW'(raw_r) * PW'(recip_r) + PW'(128);
    sc     = prod[PW-1:8];
    hs_nxt = (sc > (PW-8)'(24'hFFFFFF)) ? HW'(24'hFFFFFF) : HW'(sc);
  end

  // face vector and vertex sums
  function automatic hvn_pkg::comp_t fx(input logic [3*FCW-1:0] v, input int k);
    logic signed [FCW-1:0] c;
    c = v[k*FCW +: FCW];
    return hvn_pkg::comp_t'(c);
  endfunction

  always_comb begin
    face_vec.x = hvn_pkg::comp_t'({2'b00, h2_r}) - hvn_pkg::comp_t'({2'b00, h1_r});
    face_vec.y = hvn_pkg::FACE_Y;
    face_vec.z = hvn_pkg::comp_t'({2'b00, h1_r}) - hvn_pkg::comp_t'({2'b00, hs_r});
    sum2.x = (col_r != '0 ? fx(left_r, 2) : '0) + (has_cur ? fx(cur_r, 2) : '0);
    sum2.y = (col_r != '0 ? fx(left_r, 1) : '0) + (has_cur ? fx(cur_r, 1) : '0);
    sum2.z = (col_r != '0 ? fx(left_r, 0) : '0) + (has_cur ? fx(cur_r, 0) : '0);
    sum1 = sum2;
    if (row_r > RW'(1)) begin
      sum1.x = sum2.x + (col_r != '0 ? fx(pfl_r, 2) : '0) + (has_cur ? fx(pfc_r, 2) : '0);
      sum1.y = sum2.y + (col_r != '0 ? fx(pfl_r, 1) : '0) + (has_cur ? fx(pfc_r, 1) : '0);
      sum1.z = sum2.z + (col_r != '0 ? fx(pfl_r, 0) : '0) + (has_cur ? fx(pfc_r, 0) : '0);
    end
  end

  // normalizer request
  always_comb begin
    norm_start = (state_r == T_FACE) || (state_r == T_V1) || (state_r == T_V2);
    case (state_r)
      T_FACE:  norm_vec = face_vec;
      T_V1:    norm_vec = sum1;
      default: norm_vec = sum2;
    endcase
    norm_res = {nx, ny, nz};
  end

  hvn_norm #(
    .FRAC_BITS(NORMAL_FRAC_BITS)
  ) u_norm (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (norm_start),
    .vec_in (norm_vec),
    .done   (norm_done),
    .nx     (nx),
    .ny     (ny),
    .nz     (nz)
  );

  // line store read addresses and write enables
  always_comb begin
    ht_raddr = (state_r == T_RD1) ? col_r + 1'b1 : col_r;
    fc_raddr = (state_r == T_RD1) ? col_r : col_r - 1'b1;
    ht_we    = (state_r == T_FIN);
    fc_we    = (state_r == T_FIN) && (row_r != '0) && (col_r != '0);
  end

  hvn_ram #(
    .WIDTH(HW),
    .DEPTH(MAX_WIDTH)
  ) u_height_ram (
    .clk   (clk),
    .we    (ht_we),
    .waddr (col_r),
    .wdata (hs_r),
    .raddr (ht_raddr),
    .rdata (ht_q)
  );

  hvn_ram #(
    .WIDTH(3 * FCW),
    .DEPTH(MAX_WIDTH)
  ) u_face_ram (
    .clk   (clk),
    .we    (fc_we),
    .waddr (col_r - 1'b1),
    .wdata (left_r),
    .raddr (fc_raddr),
    .rdata (fc_q)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign out_load = ((state_r == T_PUT1) || (state_r == T_PUT2)) && out_free;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gw_r    <= hvn_pkg::SIZE_W'(256);
      gh_r    <= hvn_pkg::SIZE_W'(256);
      recip_r <= hvn_pkg::RECIP_W'(65536);
    end else if (cfg_we) begin
      unique case (cfg_index)
        hvn_pkg::CFG_GRID_WIDTH:  gw_r    <= cfg_data[hvn_pkg::SIZE_W-1:0];
        hvn_pkg::CFG_GRID_HEIGHT: gh_r    <= cfg_data[hvn_pkg::SIZE_W-1:0];
        hvn_pkg::CFG_SCALE_RECIP: recip_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // sample sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      col_r       <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
      left_r      <= '0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        T_IDLE: begin
          if (in_valid) begin
            raw_r   <= in_height_sample;
            state_r <= T_SCALE;
          end
        end
        T_SCALE: begin
          hs_r    <= hs_nxt;
          state_r <= T_RD1;
        end
        T_RD1: begin
          h1_r    <= ht_q;
          pfl_r   <= fc_q;
          state_r <= T_RD2;
        end
        T_RD2: begin
          h2_r  <= ht_q;
          pfc_r <= fc_q;
          cur_r <= '0;
          if (row_r == '0) begin
            state_r <= T_FIN;
          end else if (has_cur) begin
            state_r <= T_FACE;
          end else begin
            state_r <= T_V1;
          end
        end
        T_FACE:  state_r <= T_FWAIT;
        T_FWAIT: begin
          if (norm_done) begin
            cur_r   <= norm_res;
            state_r <= T_V1;
          end
        end
        T_V1:    state_r <= T_V1W;
        T_V1W: begin
          if (norm_done) begin
            state_r <= T_PUT1;
          end
        end
        // vertex of the row above
        T_PUT1: begin
          if (out_free) begin
            onx_r       <= hvn_pkg::OUT_W'(nx);
            ony_r       <= hvn_pkg::OUT_W'(ny);
            onz_r       <= hvn_pkg::OUT_W'(nz);
            ocol_r      <= RW'(col_r);
            orow_r      <= row_r - 1'b1;
            olast_r     <= 1'b0;
            state_r     <= lastrow ? T_V2 : T_FIN;
          end
        end
        T_V2:    state_r <= T_V2W;
        T_V2W: begin
          if (norm_done) begin
            state_r <= T_PUT2;
          end
        end
        // vertex of the last row itself
        T_PUT2: begin
          if (out_free) begin
            onx_r       <= hvn_pkg::OUT_W'(nx);
            ony_r       <= hvn_pkg::OUT_W'(ny);
            onz_r       <= hvn_pkg::OUT_W'(nz);
            ocol_r      <= RW'(col_r);
            orow_r      <= row_r;
            olast_r     <= lastcol;
            state_r     <= T_FIN;
          end
        end
        // line store writes and counter advance
        T_FIN: begin
          if (row_r != '0) begin
            left_r <= cur_r;
          end
          if (lastcol) begin
            col_r <= '0;
            row_r <= lastrow ? '0 : row_r + 1'b1;
          end else begin
            col_r <= col_r + 1'b1;
          end
          state_r <= T_IDLE;
        end
        default: begin
          state_r <= T_IDLE;
        end
      endcase
    end
  end

  assign in_stall          = (state_r != T_IDLE);
  assign out_valid         = out_valid_r;
  assign out_normal_x      = onx_r;
  assign out_normal_y      = ony_r;
  assign out_normal_z      = onz_r;
  assign out_vertex_column = ocol_r;
  assign out_vertex_row    = orow_r;
  assign out_last_vertex   = olast_r;

endmodule
